[rtl/core/bzs_pkg.sv]
// Shared types, codes and step tables for the buzzer pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

package bzs_pkg;

	// Step table geometry and field widths.
	localparam int StepCount = 11;
	localparam int StepW     = 4;
	localparam int ElapsedW  = 9;
	localparam int ToneW     = 12;

	localparam logic [StepW-1:0]    LastRomStep = StepW'(StepCount - 1);
	localparam logic [ElapsedW-1:0] ElapsedMax  = '1;

	// Item kind codes.
	typedef enum logic {
		KIND_PLAY = 1'b0,
		KIND_TICK = 1'b1
	} bzs_kind_t;

	// Input beat: a play request or a millisecond tick.
	typedef struct packed {
		bzs_kind_t  kind;
		logic [1:0] sound;
	} bzs_in_t;

	// Result beat: current tone and playing flag.
	typedef struct packed {
		logic [ToneW-1:0] tone_hz;
		logic             playing;
	} bzs_out_t;

	// Tone frequency of each ROM step, in hertz.
	function automatic logic [ToneW-1:0] step_freq(input logic [StepW-1:0] idx);
		logic [ToneW-1:0] f;
		case (idx)
			4'd0:    f = 12'd1000;
			4'd1:    f = 12'd0;
			4'd2:    f = 12'd1500;
			4'd3:    f = 12'd2000;
			4'd4:    f = 12'd0;
			4'd5:    f = 12'd600;
			4'd6:    f = 12'd0;
			4'd7:    f = 12'd600;
			4'd8:    f = 12'd0;
			4'd9:    f = 12'd600;
			default: f = 12'd2500;
		endcase
		return f;
	endfunction

	// Duration of each ROM step, in milliseconds.
	function automatic logic [ElapsedW-1:0] step_dur(input logic [StepW-1:0] idx);
		logic [ElapsedW-1:0] d;
		case (idx)
			4'd0:    d = 9'd60;
			4'd1:    d = 9'd30;
			4'd2:    d = 9'd80;
			4'd3:    d = 9'd40;
			4'd4:    d = 9'd40;
			4'd5:    d = 9'd100;
			4'd6:    d = 9'd100;
			4'd7:    d = 9'd100;
			4'd8:    d = 9'd100;
			4'd9:    d = 9'd100;
			default: d = 9'd300;
		endcase
		return d;
	endfunction

	// First ROM step of each pattern.
	function automatic logic [StepW-1:0] pat_first(input logic [1:0] sound);
		logic [StepW-1:0] s;
		case (sound)
			2'd0:    s = 4'd0;
			2'd1:    s = 4'd3;
			2'd2:    s = 4'd5;
			default: s = 4'd10;
		endcase
		return s;
	endfunction

	// Last ROM step of each pattern.
	function automatic logic [StepW-1:0] pat_last(input logic [1:0] sound);
		logic [StepW-1:0] s;
		case (sound)
			2'd0:    s = 4'd2;
			2'd1:    s = 4'd4;
			2'd2:    s = 4'd9;
			default: s = 4'd10;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[rtl/core/buzzer_pattern_sequencer.sv]
// Buzzer pattern sequencer: top level.
//
// Input channel (item_valid / item_stall / item): each beat is either a play
// request that selects one of four alert patterns, or a one-millisecond tick.
// Output channel (result_valid / result_stall / result): exactly one result
// beat per input beat, in order, carrying the tone frequency and playing flag
// after that beat has been applied.
// Configuration: cfg_we writes cfg_data into the sound enable bit. While it
// is clear, play requests are refused; a pattern already running finishes.
// An accepted beat passes the input register, then the result register.
// Throughput is one beat per cycle unless the receiver stalls; the pattern
// state is updated in the single compute step between the two registers.
// Reset clears both stages and returns to idle with sound enabled.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; item_stall rises only when both
// stages are full.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_pattern_sequencer import bzs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire bzs_in_t item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output bzs_out_t     result,
	input  wire logic    cfg_we,
	input  wire logic    cfg_data
);

	logic     advance;
	logic     valid_s1;
	bzs_in_t  item_s1;
	bzs_out_t res_d;

	// Input register.
	bzs_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// Pattern state and step logic.
	bzs_seq_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (valid_s1 && advance),
		.item_s1  (item_s1),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.res_d    (res_d)
	);

	// Result register.
	bzs_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.res_d        (res_d),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

[rtl/core/bzs_in_reg.sv]
// Input register stage of the buzzer pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

module bzs_in_reg import bzs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire bzs_in_t item,
	input  wire logic    advance,
	output logic         valid_s1,
	output bzs_in_t      item_s1
);

	// The stage takes a new beat when it is empty or its beat moves on.
	logic load;

	assign load       = !valid_s1 || advance;
	assign item_stall = !load;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= item_valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (load && item_valid) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

[rtl/core/bzs_seq_core.sv]
// Pattern state and next-state logic of the buzzer pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

module bzs_seq_core import bzs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    fire,
	input  wire bzs_in_t item_s1,
	input  wire logic    cfg_we,
	input  wire logic    cfg_data,
	output bzs_out_t     res_d
);

	logic                sound_enable_q;
	logic [StepW-1:0]    rom_step_q;
	logic [StepW-1:0]    last_step_q;
	logic [ElapsedW-1:0] elapsed_q;
	logic                active_q;

	logic [StepW-1:0]    rom_step_d;
	logic [StepW-1:0]    last_step_d;
	logic [ElapsedW-1:0] elapsed_d;
	logic                active_d;
	logic [ElapsedW-1:0] elapsed_inc;
	logic [StepW-1:0]    cur_idx;
	logic [StepW-1:0]    new_idx;

	// ROM index of the current step, clamped to the table.
	assign cur_idx = (rom_step_q > LastRomStep) ? LastRomStep : rom_step_q;
	assign elapsed_inc = (elapsed_q < ElapsedMax) ? elapsed_q + 1'b1 : elapsed_q;

	// Next state for the beat in the input stage.
	always_comb begin
		rom_step_d  = rom_step_q;
		last_step_d = last_step_q;
		elapsed_d   = elapsed_q;
		active_d    = active_q;
		if (item_s1.kind == KIND_PLAY) begin
			if (sound_enable_q) begin
				rom_step_d  = pat_first(item_s1.sound);
				last_step_d = pat_last(item_s1.sound);
				elapsed_d   = '0;
				active_d    = 1'b1;
			end
		end else if (active_q) begin
			elapsed_d = elapsed_inc;
			if (elapsed_inc >= step_dur(cur_idx)) begin
				if (rom_step_q >= last_step_q) begin
					active_d = 1'b0;
				end else begin
					rom_step_d = rom_step_q + 1'b1;
					elapsed_d  = '0;
				end
			end
		end
	end

	// Result from the updated state.
	assign new_idx = (rom_step_d > LastRomStep) ? LastRomStep : rom_step_d;
	assign res_d.tone_hz = active_d ? step_freq(new_idx) : '0;
	assign res_d.playing = active_d;

	// Enable register and pattern state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_enable_q <= 1'b1;
			rom_step_q     <= '0;
			last_step_q    <= '0;
			elapsed_q      <= '0;
			active_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				sound_enable_q <= cfg_data;
			end
			if (fire) begin
				rom_step_q  <= rom_step_d;
				last_step_q <= last_step_d;
				elapsed_q   <= elapsed_d;
				active_q    <= active_d;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/bzs_out_reg.sv]
// Result register stage of the buzzer pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

module bzs_out_reg import bzs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     valid_s1,
	input  wire bzs_out_t res_d,
	output logic          advance,
	output logic          result_valid,
	input  wire logic     result_stall,
	output bzs_out_t      result
);

	// The register can take a result when it is empty or being drained.
	assign advance = !result_valid || !result_stall;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result <= res_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/bzs_checker.sv]
// Port-level checks for the buzzer pattern sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bzs_checker import bzs_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     item_valid,
	input wire logic     item_stall,
	input wire bzs_in_t  item,
	input wire logic     result_valid,
	input wire logic     result_stall,
	input wire bzs_out_t result
);

	// A stalled input beat stays put until it is taken.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled input beat changed");

	// A stalled result beat stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// With the result register empty, the input side is never stalled.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled while result register empty");

	// A silent result is reported whenever no pattern is playing.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.playing |-> result.tone_hz == '0)
		else $error("tone reported while idle");

	// A playing result carries one of the table frequencies.
	a_tone_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.playing |->
			(result.tone_hz == 12'd0) || (result.tone_hz == 12'd600) ||
			(result.tone_hz == 12'd1000) || (result.tone_hz == 12'd1500) ||
			(result.tone_hz == 12'd2000) || (result.tone_hz == 12'd2500))
		else $error("tone outside the step table");

endmodule

bind buzzer_pattern_sequencer bzs_checker u_bzs_checker (.*);

`default_nettype wire
